[hw/rtl/epwc_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the encoder pulse width counter
// no dependencies; imported by the top level

package epwc_pkg;

  localparam int CH_W         = 2;
  localparam int NUM_CHANNELS = 1 << CH_W;
  localparam int TIMER_BITS   = 16;
  localparam int WIN_LOG2     = 3;
  localparam int WINDOW_DEPTH = 1 << WIN_LOG2;
  localparam int SUM_W        = TIMER_BITS + WIN_LOG2;
  localparam int WIN_ADDR_W   = CH_W + WIN_LOG2;
  localparam int WIN_WORDS    = NUM_CHANNELS * WINDOW_DEPTH;
  localparam int CNT_W        = 16;
  localparam int MAXP_W       = 15;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 15'd1024;

  // tdata layouts, padded to whole bytes
  localparam int IN_RAW_W   = CH_W + TIMER_BITS + 1;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = CH_W + 1 + TIMER_BITS + 1 + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [CH_W-1:0]       ch;
    logic [TIMER_BITS-1:0] stamp;
    logic                  pb;
  } item_t;

endpackage

[hw/rtl/encoder_pulse_width_counter.sv]
`timescale 1ns / 1ps
// encoder pulse width counter: four channel edge capture, sliding width average,
// step and turn counts. depends on epwc_pkg and epwc_ram (width window store)
//
// an accepted item waits in stage 1 and is registered onto out_* as it advances
// throughput: one item per cycle unless out_tready stalls; the window ram read is
// issued at accept and the read-modify-write completes as stage 1 advances
// reset: synchronous active low; all channels armed for a rising edge, counts,
// sums and averages zero, turn limit 1024; the window ram is not cleared

module encoder_pulse_width_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // channel, stamp, phase_b, zero pad
  input  logic [epwc_pkg::IN_DATA_W-1:0]    in_tdata,
  // op
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_channel, forward, avg_width, avg_valid, step_count, turn_count, zero pad
  output logic [epwc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // was_falling, glitch
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [epwc_pkg::MAXP_W-1:0]       cfg_wr_data
);

  import epwc_pkg::*;

  logic [MAXP_W-1:0] turn_limit_r;

  // per-channel state
  logic                  await_r  [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] stamp_r  [NUM_CHANNELS];
  logic                  phase_r  [NUM_CHANNELS];
  logic                  dir_r    [NUM_CHANNELS];
  logic [SUM_W-1:0]      sum_r    [NUM_CHANNELS];
  logic [WIN_LOG2-1:0]   ptr_r    [NUM_CHANNELS];
  logic                  full_r   [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] avg_r    [NUM_CHANNELS];
  logic [CNT_W-1:0]      steps_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]      turns_r  [NUM_CHANNELS];

  logic                  await_nxt [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] stamp_nxt [NUM_CHANNELS];
  logic                  phase_nxt [NUM_CHANNELS];
  logic                  dir_nxt   [NUM_CHANNELS];
  logic [SUM_W-1:0]      sum_nxt   [NUM_CHANNELS];
  logic [WIN_LOG2-1:0]   ptr_nxt   [NUM_CHANNELS];
  logic                  full_nxt  [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] avg_nxt   [NUM_CHANNELS];
  logic [CNT_W-1:0]      steps_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0]      turns_nxt [NUM_CHANNELS];

  // stage 1 holds the accepted item while the ram read completes
  item_t s1_r;
  logic  s1_valid_r;
  logic  s1_adv;

  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [1:0]               out_user_r;
  logic [OUT_DATA_W-1:0]    out_data_nxt;
  logic [1:0]               out_user_nxt;

  item_t                 in_item;
  logic                  in_acc;
  logic [WIN_ADDR_W-1:0] rd_addr;
  logic [TIMER_BITS-1:0] ram_rdata;
  logic                  ram_we;
  logic [WIN_ADDR_W-1:0] wr_addr;
  logic [TIMER_BITS-1:0] width;

  logic                  falling;
  logic                  glitch;
  logic [TIMER_BITS-1:0] oldest;
  logic [SUM_W-1:0]      sum_new;
  logic signed [CNT_W:0] step_ext;
  logic signed [CNT_W:0] lim;
  logic signed [CNT_W:0] neg_lim;
  logic [CH_W-1:0]       ch;
  logic                  steps_all_zero;

  assign in_item.op    = op_t'(in_tuser);
  assign in_item.ch    = in_tdata[CH_W-1:0];
  assign in_item.stamp = in_tdata[CH_W +: TIMER_BITS];
  assign in_item.pb    = in_tdata[CH_W+TIMER_BITS];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // read the slot the next width of this channel lands in, after this cycle's update
  assign rd_addr = {in_item.ch, ptr_nxt[in_item.ch]};
  assign ch      = s1_r.ch;
  assign wr_addr = {ch, ptr_r[ch]};
  assign width   = s1_r.stamp - stamp_r[ch];

  epwc_ram #(
    .WIDTH (TIMER_BITS),
    .DEPTH (WIN_WORDS)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (width),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      await_nxt[k] = await_r[k];
      stamp_nxt[k] = stamp_r[k];
      phase_nxt[k] = phase_r[k];
      dir_nxt[k]   = dir_r[k];
      sum_nxt[k]   = sum_r[k];
      ptr_nxt[k]   = ptr_r[k];
      full_nxt[k]  = full_r[k];
      avg_nxt[k]   = avg_r[k];
      steps_nxt[k] = steps_r[k];
      turns_nxt[k] = turns_r[k];
    end
    falling  = 1'b0;
    glitch   = 1'b0;
    ram_we   = 1'b0;
    oldest   = full_r[ch] ? ram_rdata : '0;
    sum_new  = sum_r[ch] - SUM_W'(oldest) + SUM_W'(width);
    step_ext = dir_r[ch] ? ($signed({steps_r[ch][CNT_W-1], steps_r[ch]}) + 17'sd1)
                         : ($signed({steps_r[ch][CNT_W-1], steps_r[ch]}) - 17'sd1);
    lim      = $signed({{(CNT_W+1-MAXP_W){1'b0}}, turn_limit_r});
    neg_lim  = -lim;

    if (s1_adv) begin
      if (s1_r.op == OP_CLEAR) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          steps_nxt[k] = '0;
          turns_nxt[k] = '0;
        end
      end else if (!await_r[ch]) begin
        stamp_nxt[ch] = s1_r.stamp;
        phase_nxt[ch] = s1_r.pb;
        dir_nxt[ch]   = s1_r.pb;
        await_nxt[ch] = 1'b1;
      end else begin
        await_nxt[ch] = 1'b0;
        falling       = 1'b1;
        if (s1_r.pb != phase_r[ch]) begin
          ram_we      = 1'b1;
          sum_nxt[ch] = sum_new;
          ptr_nxt[ch] = ptr_r[ch] + 1'b1;
          if (full_r[ch] || (ptr_r[ch] == WIN_LOG2'(WINDOW_DEPTH - 1))) begin
            full_nxt[ch] = 1'b1;
            avg_nxt[ch]  = sum_new[SUM_W-1:WIN_LOG2];
          end
          // step count carries into the turn count at either limit
          if (step_ext >= lim) begin
            turns_nxt[ch] = turns_r[ch] + 1'b1;
            steps_nxt[ch] = '0;
          end else if (step_ext <= neg_lim) begin
            turns_nxt[ch] = turns_r[ch] - 1'b1;
            steps_nxt[ch] = '0;
          end else begin
            steps_nxt[ch] = step_ext[CNT_W-1:0];
          end
        end else begin
          glitch = 1'b1;
        end
      end
    end

    out_data_nxt = '0;
    out_data_nxt[OUT_RAW_W-1:0] = {turns_nxt[ch], steps_nxt[ch], full_nxt[ch], avg_nxt[ch],
                                   dir_nxt[ch], ch};
    out_user_nxt = {glitch, falling};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_limit_r <= MAXP_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        await_r[k] <= 1'b0;
        stamp_r[k] <= '0;
        phase_r[k] <= 1'b0;
        dir_r[k]   <= 1'b0;
        sum_r[k]   <= '0;
        ptr_r[k]   <= '0;
        full_r[k]  <= 1'b0;
        avg_r[k]   <= '0;
        steps_r[k] <= '0;
        turns_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        turn_limit_r <= cfg_wr_data;
      end
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        await_r[k] <= await_nxt[k];
        stamp_r[k] <= stamp_nxt[k];
        phase_r[k] <= phase_nxt[k];
        dir_r[k]   <= dir_nxt[k];
        sum_r[k]   <= sum_nxt[k];
        ptr_r[k]   <= ptr_nxt[k];
        full_r[k]  <= full_nxt[k];
        avg_r[k]   <= avg_nxt[k];
        steps_r[k] <= steps_nxt[k];
        turns_r[k] <= turns_nxt[k];
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_item;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    steps_all_zero = 1'b1;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (steps_r[k] != '0 || turns_r[k] != '0) begin
        steps_all_zero = 1'b0;
      end
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_tready)
    else $error("input taken while stage 1 is stalled");

  a_glitch_is_falling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tuser[0])
    else $error("glitch reported on a non-falling item");

  a_avg_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[CH_W+1+TIMER_BITS]) |->
      (out_tdata[CH_W+1 +: TIMER_BITS] == '0))
    else $error("average shown before window filled");

  a_clear_zeroes_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_r.op == OP_CLEAR) |=> steps_all_zero)
    else $error("clear left a step or turn count set");

endmodule

[hw/rtl/epwc_ram.sv]
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module epwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
